@@ hw/rtl/gndm_pkg.sv @@
// Shared constants, types and state codes for the gradient norm deviation mean block.
`timescale 1ns / 1ps
`default_nettype none

package gndm_pkg;

   // Point count limit and the counter width it needs
   localparam int unsigned MAX_POINTS = 1048576;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   // Field and datapath widths
   localparam int GRAD_W = 16;
   localparam int SQ_W   = 32;
   localparam int NORM_W = 16;
   localparam int SUM_W  = 37;
   localparam int MEAN_W = 16;
   localparam int PTS_W  = 21;

   // One in Q4.12
   localparam logic [NORM_W-1:0] UNIT_Q12 = 16'd4096;

   // Iteration counts of the shared root and divide steps
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int DIV_STEPS  = SUM_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   // Queue between the front and back parts
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [SQ_W-1:0] norm_sq;
      logic            last_point;
   } queue_entry_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_SQRT,
      BACK_ACC,
      BACK_DIV,
      BACK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

@@ hw/rtl/gndm_req_if.sv @@
// Request channel interface: one grid point per request.
`timescale 1ns / 1ps
`default_nettype none

interface gndm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [gndm_pkg::GRAD_W-1:0]  grad_x;
   logic signed [gndm_pkg::GRAD_W-1:0]  grad_y;
   logic signed [gndm_pkg::GRAD_W-1:0]  grad_z;
   logic                                last_point;

   modport source (output valid, output grad_x, output grad_y, output grad_z,
                   output last_point, input ready);
   modport sink   (input valid, input grad_x, input grad_y, input grad_z,
                   input last_point, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gndm_rsp_if.sv @@
// Response channel interface: one mean per field.
`timescale 1ns / 1ps
`default_nettype none

interface gndm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gndm_pkg::MEAN_W-1:0]   mean_roughness;
   logic [gndm_pkg::PTS_W-1:0]    points_counted;

   modport source (output valid, output mean_roughness, output points_counted,
                   input ready);
   modport sink   (input valid, input mean_roughness, input points_counted,
                   output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gndm_front.sv @@
// Front part: accepts grid points, squares the components and forms the squared norm.
`timescale 1ns / 1ps
`default_nettype none

module gndm_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   gndm_req_if.sink                      req_bus,
   output gndm_pkg::queue_entry_type     push_entry,
   output logic                          push_valid,
   input  wire logic                     push_ready
);

   logic [gndm_pkg::SQ_W-1:0]   sq_x_ff, sq_y_ff, sq_z_ff;
   logic [gndm_pkg::SQ_W-1:0]   sq_x_in, sq_y_in, sq_z_in;
   logic                        last_ff;
   logic                        stage_valid_ff, stage_valid_in;
   logic                        advance;
   logic                        accept;
   logic [gndm_pkg::GRAD_W-1:0] mag_x, mag_y, mag_z;

   // Take a new request whenever the square stage is empty or drains this cycle
   assign advance       = !stage_valid_ff || push_ready;
   assign req_bus.ready = advance;
   assign accept        = req_bus.valid && advance;

   // Magnitudes; the most negative value maps to 32768 as unsigned
   assign mag_x = req_bus.grad_x[gndm_pkg::GRAD_W-1] ? gndm_pkg::GRAD_W'(-req_bus.grad_x)
                                                    : gndm_pkg::GRAD_W'(req_bus.grad_x);
   assign mag_y = req_bus.grad_y[gndm_pkg::GRAD_W-1] ? gndm_pkg::GRAD_W'(-req_bus.grad_y)
                                                    : gndm_pkg::GRAD_W'(req_bus.grad_y);
   assign mag_z = req_bus.grad_z[gndm_pkg::GRAD_W-1] ? gndm_pkg::GRAD_W'(-req_bus.grad_z)
                                                    : gndm_pkg::GRAD_W'(req_bus.grad_z);

   // Square each component, one multiplier each
   assign sq_x_in = gndm_pkg::SQ_W'(mag_x) * gndm_pkg::SQ_W'(mag_x);
   assign sq_y_in = gndm_pkg::SQ_W'(mag_y) * gndm_pkg::SQ_W'(mag_y);
   assign sq_z_in = gndm_pkg::SQ_W'(mag_z) * gndm_pkg::SQ_W'(mag_z);

   assign stage_valid_in = accept || (stage_valid_ff && !push_ready);

   // Hold the squares until the queue takes their sum
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         sq_z_ff <= sq_z_in;
         last_ff <= req_bus.last_point;
      end
   end

   // Sum of three squares stays below 2^32
   assign push_valid            = stage_valid_ff;
   assign push_entry.norm_sq    = sq_x_ff + sq_y_ff + sq_z_ff;
   assign push_entry.last_point = last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/gndm_queue.sv @@
// Short queue that decouples the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module gndm_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire gndm_pkg::queue_entry_type push_entry,
   input  wire logic                      push_valid,
   output logic                           push_ready,
   output gndm_pkg::queue_entry_type      pop_entry,
   output logic                           pop_valid,
   input  wire logic                      pop
);

   gndm_pkg::queue_entry_type      slot_ff [gndm_pkg::QUEUE_DEPTH];
   logic [gndm_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [gndm_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [gndm_pkg::QPTR_W:0]      fill_ff, fill_in;
   logic                           do_push, do_pop;

   assign push_ready = (fill_ff != (gndm_pkg::QPTR_W + 1)'(gndm_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop && pop_valid;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/gndm_back.sv @@
// Back part: iterative square root, deviation accumulate, iterative mean divide, response.
`timescale 1ns / 1ps
`default_nettype none

module gndm_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire gndm_pkg::queue_entry_type pop_entry,
   input  wire logic                      pop_valid,
   output logic                           pop,
   gndm_rsp_if.source                     rsp_bus
);

   localparam int SQ_W   = gndm_pkg::SQ_W;
   localparam int SUM_W  = gndm_pkg::SUM_W;
   localparam int CNT_W  = gndm_pkg::CNT_W;
   localparam int STEP_W = gndm_pkg::STEP_W;

   gndm_pkg::back_state_type  state_ff, state_in;

   logic [SQ_W-1:0]           rad_ff, rad_in;
   logic [SQ_W-1:0]           root_ff, root_in;
   logic [SQ_W-1:0]           bit_ff, bit_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      last_ff, last_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [SUM_W-1:0]          quo_ff, quo_in;
   logic [CNT_W-1:0]          rem_ff, rem_in;
   logic [CNT_W-1:0]          den_ff, den_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [gndm_pkg::MEAN_W-1:0] mean_ff, mean_in;
   logic [gndm_pkg::PTS_W-1:0]  pts_ff, pts_in;

   logic [SQ_W:0]             sqrt_trial;
   logic [gndm_pkg::NORM_W-1:0] norm;
   logic [gndm_pkg::NORM_W-1:0] dev;
   logic [SUM_W:0]            sum_wide;
   logic [SUM_W-1:0]          sum_next;
   logic [CNT_W-1:0]          count_next;
   logic [CNT_W:0]            div_trial;
   logic                      div_ge;
   logic [31:0]               den_wide;
   logic                      emit_load;

   // One digit step of the floor square root
   assign sqrt_trial = (SQ_W + 1)'(root_ff) + (SQ_W + 1)'(bit_ff);

   // Deviation of the norm from one
   assign norm = root_ff[gndm_pkg::NORM_W-1:0];
   assign dev  = (norm >= gndm_pkg::UNIT_Q12) ? norm - gndm_pkg::UNIT_Q12
                                              : gndm_pkg::UNIT_Q12 - norm;

   // Saturating accumulate, skipped once the count is full
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(dev);
   always_comb begin
      sum_next   = sum_ff;
      count_next = count_ff;
      if (count_ff < CNT_W'(gndm_pkg::MAX_POINTS)) begin
         sum_next   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
         count_next = count_ff + 1'b1;
      end
   end

   // One quotient bit of the restoring divide
   assign div_trial = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge    = (div_trial >= {1'b0, den_ff});
   assign den_wide  = 32'(den_ff);

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.mean_roughness = mean_ff;
   assign rsp_bus.points_counted = pts_ff;

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in  = state_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      step_in   = step_ff;
      last_in   = last_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      mean_in   = mean_ff;
      pts_in    = pts_ff;
      pop       = 1'b0;
      emit_load = 1'b0;
      case (state_ff)
         gndm_pkg::BACK_IDLE: begin
            if (pop_valid) begin
               pop      = 1'b1;
               rad_in   = pop_entry.norm_sq;
               last_in  = pop_entry.last_point;
               root_in  = '0;
               bit_in   = SQ_W'(1) << (SQ_W - 2);
               step_in  = '0;
               state_in = gndm_pkg::BACK_SQRT;
            end
         end
         gndm_pkg::BACK_SQRT: begin
            if ((SQ_W + 1)'(rad_ff) >= sqrt_trial) begin
               rad_in  = rad_ff - sqrt_trial[SQ_W-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(gndm_pkg::SQRT_STEPS - 1)) begin
               state_in = gndm_pkg::BACK_ACC;
            end
         end
         gndm_pkg::BACK_ACC: begin
            if (last_ff) begin
               quo_in   = sum_next;
               den_in   = count_next;
               rem_in   = '0;
               step_in  = '0;
               sum_in   = '0;
               count_in = '0;
               state_in = gndm_pkg::BACK_DIV;
            end else begin
               sum_in   = sum_next;
               count_in = count_next;
               state_in = gndm_pkg::BACK_IDLE;
            end
         end
         gndm_pkg::BACK_DIV: begin
            quo_in  = {quo_ff[SUM_W-2:0], div_ge};
            rem_in  = div_ge ? CNT_W'(div_trial - {1'b0, den_ff}) : div_trial[CNT_W-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(gndm_pkg::DIV_STEPS - 1)) begin
               state_in = gndm_pkg::BACK_EMIT;
            end
         end
         gndm_pkg::BACK_EMIT: begin
            // Wait for the response register to drain, then load it
            if (!rsp_valid_ff) begin
               emit_load = 1'b1;
               if (den_ff == '0) begin
                  mean_in = '0;
               end else if (quo_ff > SUM_W'({gndm_pkg::MEAN_W{1'b1}})) begin
                  mean_in = '1;
               end else begin
                  mean_in = quo_ff[gndm_pkg::MEAN_W-1:0];
               end
               pts_in   = den_wide[gndm_pkg::PTS_W-1:0];
               state_in = gndm_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = gndm_pkg::BACK_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit_load || (rsp_valid_ff && !rsp_bus.ready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gndm_pkg::BACK_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      step_ff <= step_in;
      last_ff <= last_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      mean_ff <= mean_in;
      pts_ff  <= pts_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/gradient_norm_deviation_mean_top.sv @@
// Top level of the gradient norm deviation mean block.
`timescale 1ns / 1ps
`default_nettype none

// Each request carries one grid point (three signed Q4.12 gradient components and a
// last flag). The block takes the floor square root of the squared norm, adds |norm - 1|
// to a running sum and counts the point (up to MAX_POINTS points; later ones are ignored).
// The request marked last yields one response: the floored mean in Q4.12, saturated to
// 16 bits, and the point count; the sum and count then restart from zero. The front part
// accepts a request each cycle while its square stage can drain into a four-entry queue;
// the back part handles one point at a time (pop, 16 root steps, accumulate) on the shared
// one-digit square root unit. A last point then runs the one-bit-per-cycle divider and the
// response load. The response register lets the back part continue while a response waits.

module gradient_norm_deviation_mean_top (
   input  wire logic  clock,
   input  wire logic  reset,
   gndm_req_if.sink   req_bus,
   gndm_rsp_if.source rsp_bus
);

   gndm_pkg::queue_entry_type push_entry;
   gndm_pkg::queue_entry_type pop_entry;
   logic                      push_valid, push_ready;
   logic                      pop_valid, pop;

   gndm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   gndm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop        (pop)
   );

   gndm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_entry (pop_entry),
      .pop_valid (pop_valid),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

@@ test/gndm_mean_checker.sv @@
// Checker that predicts each field mean from the accepted requests and compares the responses.
`timescale 1ns / 1ps

module gndm_mean_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   gndm_req_if         req_bus,
   gndm_rsp_if         rsp_bus,
   output int unsigned error_count,
   output int unsigned pending_means
);
   import gndm_pkg::*;

   localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
   localparam longint unsigned MEAN_LIMIT = (64'd1 << MEAN_W) - 64'd1;

   typedef struct packed {
      logic [MEAN_W-1:0] mean;
      logic [PTS_W-1:0]  points;
   } field_mean_t;

   // Running deviation sum and point count of the field in progress
   longint unsigned   deviation_total;
   logic [CNT_W-1:0]  field_points;
   field_mean_t       expected_means[$];
   int unsigned       mismatches = 0;
   int unsigned       waiting = 0;

   assign error_count   = mismatches;
   assign pending_means = waiting;

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      mismatches++;
   endtask

   // Floor square root, one result bit per pass from the top down
   function automatic logic [NORM_W-1:0] floor_root(input longint unsigned n);
      logic [NORM_W-1:0] root;
      logic [NORM_W-1:0] cand;
      longint unsigned   wide;
      root = '0;
      for (int b = NORM_W - 1; b >= 0; b--) begin
         cand = root | (NORM_W'(1) << b);
         wide = longint'(cand);
         if (wide * wide <= n)
            root = cand;
      end
      return root;
   endfunction

   // Fold one grid point into the field; queue the mean when the point closes the field
   task automatic absorb_point(input logic signed [GRAD_W-1:0] gx,
                               input logic signed [GRAD_W-1:0] gy,
                               input logic signed [GRAD_W-1:0] gz,
                               input logic last);
      longint signed      sx, sy, sz;
      longint unsigned    norm_sq;
      logic [NORM_W-1:0]  norm;
      longint unsigned    deviation;
      longint unsigned    mean;
      field_mean_t        result;
      sx = gx;
      sy = gy;
      sz = gz;
      norm_sq = longint'(sx * sx + sy * sy + sz * sz);
      norm = floor_root(norm_sq);
      deviation = (norm >= UNIT_Q12) ? longint'(norm - UNIT_Q12) : longint'(UNIT_Q12 - norm);

      // Drop points once the count is full
      if (longint'(field_points) < longint'(MAX_POINTS)) begin
         deviation_total += deviation;
         if (deviation_total > SUM_LIMIT)
            deviation_total = SUM_LIMIT;
         field_points++;
      end

      if (last) begin
         mean = (field_points != 0) ? deviation_total / longint'(field_points) : 0;
         if (mean > MEAN_LIMIT)
            mean = MEAN_LIMIT;
         result.mean   = mean[MEAN_W-1:0];
         result.points = field_points[PTS_W-1:0];
         expected_means.push_back(result);
         deviation_total = 0;
         field_points = '0;
      end
   endtask

   // Compare one accepted response with the oldest expected mean
   task automatic check_mean();
      field_mean_t want;
      if (expected_means.size() == 0) begin
         report_mismatch($sformatf("response with no mean pending: mean_roughness %0d points_counted %0d",
                                   rsp_bus.mean_roughness, rsp_bus.points_counted));
      end else begin
         want = expected_means.pop_front();
         if (rsp_bus.mean_roughness !== want.mean)
            report_mismatch($sformatf("mean_roughness got %0d expected %0d",
                                      rsp_bus.mean_roughness, want.mean));
         if (rsp_bus.points_counted !== want.points)
            report_mismatch($sformatf("points_counted got %0d expected %0d",
                                      rsp_bus.points_counted, want.points));
      end
   endtask

   // Check responses before absorbing the request of the same edge
   always @(posedge clock) begin
      if (reset) begin
         deviation_total = 0;
         field_points = '0;
         expected_means.delete();
         waiting <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_mean();
         if (req_bus.valid && req_bus.ready)
            absorb_point(req_bus.grad_x, req_bus.grad_y, req_bus.grad_z, req_bus.last_point);
         waiting <= expected_means.size();
      end
   end

endmodule

@@ test/tb_gradient_norm_deviation_mean_top.sv @@
// Testbench top: drives grid point requests and response stalls and reports the verdict.
`timescale 1ns / 1ps

module tb_gradient_norm_deviation_mean_top;
   import gndm_pkg::*;

   localparam int RANDOM_POINTS  = 1430;
   localparam int PRESSURE_HOLD  = 600;
   localparam int DRAIN_CYCLES   = 160;
   localparam int WATCHDOG_LIMIT = 5000;

   logic        clock;
   logic        reset;
   int unsigned error_count;
   int unsigned pending_means;
   int unsigned idle_cycles = 0;
   int unsigned means_taken = 0;
   bit          quiet_sender = 1'b0;
   bit          quiet_receiver = 1'b0;

   gndm_req_if req_bus ();
   gndm_rsp_if rsp_bus ();

   gradient_norm_deviation_mean_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   gndm_mean_checker mean_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .error_count   (error_count),
      .pending_means (pending_means)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic send_point(input logic signed [GRAD_W-1:0] gx,
                             input logic signed [GRAD_W-1:0] gy,
                             input logic signed [GRAD_W-1:0] gz,
                             input logic last);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.grad_x     <= gx;
      req_bus.grad_y     <= gy;
      req_bus.grad_z     <= gz;
      req_bus.last_point <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Draw a grid point: random, close to unit norm, small, or a corner value
   task automatic make_point(output logic signed [GRAD_W-1:0] gx,
                             output logic signed [GRAD_W-1:0] gy,
                             output logic signed [GRAD_W-1:0] gz);
      logic signed [GRAD_W-1:0] comp [3];
      int kind;
      int axis;
      int mag;
      kind = $urandom_range(0, 99);
      foreach (comp[i]) begin
         if (kind < 40)
            comp[i] = GRAD_W'($urandom);
         else if (kind < 75)
            comp[i] = GRAD_W'(int'($urandom_range(0, 512)) - 256);
         else if (kind < 90)
            comp[i] = GRAD_W'(int'($urandom_range(0, 1024)) - 512);
         else begin
            case ($urandom_range(0, 6))
               0: comp[i] = 16'sh8000;
               1: comp[i] = 16'sh7fff;
               2: comp[i] = 16'sd0;
               3: comp[i] = -16'sd1;
               4: comp[i] = 16'sd1;
               5: comp[i] = 16'sd4096;
               default: comp[i] = -16'sd4096;
            endcase
         end
      end
      // Put one axis near one so the norm lands on either side of it
      if (kind >= 40 && kind < 75) begin
         axis = $urandom_range(0, 2);
         mag = 4032 + int'($urandom_range(0, 128));
         comp[axis] = $urandom_range(0, 1) ? GRAD_W'(mag) : GRAD_W'(-mag);
      end
      gx = comp[0];
      gy = comp[1];
      gz = comp[2];
   endtask

   // Stimulus: reset, directed fields, random fields, drain and verdict
   initial begin
      logic signed [GRAD_W-1:0] gx, gy, gz;
      int sent;
      int field_len;
      int sel;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.grad_x     <= '0;
      req_bus.grad_y     <= '0;
      req_bus.grad_z     <= '0;
      req_bus.last_point <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Single point fields: zero, exact unit on each axis, corners, near unit
      send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_point(16'sd4096, 16'sd0, 16'sd0, 1'b1);
      send_point(16'sd0, -16'sd4096, 16'sd0, 1'b1);
      send_point(16'sd0, 16'sd0, 16'sd4096, 1'b1);
      send_point(16'sh7fff, 16'sd0, 16'sd0, 1'b1);
      send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
      send_point(16'sd2365, 16'sd2365, 16'sd2365, 1'b1);
      send_point(-16'sd1, 16'sd1, -16'sd1, 1'b1);

      // Multi point fields mixing deviations above and below one
      send_point(16'sd4097, 16'sd0, 16'sd0, 1'b0);
      send_point(16'sd4095, 16'sd0, 16'sd0, 1'b0);
      send_point(16'sd0, 16'sh8000, 16'sd0, 1'b0);
      send_point(16'sh5555, 16'shaaaa, 16'sd0, 1'b0);
      send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_point(16'sh8000, 16'sh7fff, 16'sd0, 1'b0);
      send_point(16'sd1, 16'sd2, 16'sd3, 1'b0);
      send_point(-16'sd4096, -16'sd4096, 16'sd0, 1'b0);
      send_point(16'sd2896, 16'sd2896, 16'sd0, 1'b0);
      send_point(-16'sd2896, 16'sd0, 16'sd2896, 1'b1);

      // Random fields, mostly short, a few long
      sent = 0;
      while (sent < RANDOM_POINTS) begin
         sel = $urandom_range(0, 99);
         if (sel < 80)
            field_len = $urandom_range(1, 12);
         else if (sel < 95)
            field_len = $urandom_range(13, 60);
         else
            field_len = $urandom_range(61, 250);
         quiet_sender = ($urandom_range(0, 3) == 0);
         for (int p = 0; p < field_len; p++) begin
            make_point(gx, gy, gz);
            send_point(gx, gy, gz, p == field_len - 1);
         end
         sent += field_len;
      end
      req_bus.valid <= 1'b0;

      // Let the count of the last request's mean settle, then wait for it
      @(posedge clock);
      while (pending_means != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_means == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Response side: stall a random time once a response shows, hold off long twice
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (means_taken % 16 == 0)
            quiet_receiver = ($urandom_range(0, 2) == 0);
         gap = quiet_receiver ? 0 : $urandom_range(0, 4);
         if (means_taken == 20 || means_taken == 80) begin
            rsp_bus.ready <= 1'b0;
            repeat (PRESSURE_HOLD) @(posedge clock);
         end else if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clock);
            while (!rsp_bus.valid) @(posedge clock);
            repeat (gap - 1) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         means_taken++;
      end
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

@@ files.f @@
hw/rtl/gndm_pkg.sv
hw/rtl/gndm_req_if.sv
hw/rtl/gndm_rsp_if.sv
hw/rtl/gndm_front.sv
hw/rtl/gndm_queue.sv
hw/rtl/gndm_back.sv
hw/rtl/gradient_norm_deviation_mean_top.sv
test/gndm_mean_checker.sv
test/tb_gradient_norm_deviation_mean_top.sv
